>>> sv/pbor_pkg.sv
package pbor_pkg;

    localparam int unsigned RING_DEPTH_DEF = 256;

    localparam int BASE_W  = 48;
    localparam int SIZE_W  = 32;
    localparam int PROD_W  = 48;
    localparam int ID_W    = 16;
    localparam int TAIL_W  = 16;
    localparam int ADDR_W  = 64;
    localparam int STALE_W = 32;
    localparam int BYTE_W  = 8;
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 2;

    localparam logic [ACT_W-1:0] ACT_RECYCLE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CLAIM   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PUBLISH = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STAT_W-1:0] ST_STALE  = 2'd2;

    localparam logic CFG_BASE = 1'b0;
    localparam logic CFG_SIZE = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 32'd4096;

endpackage

>>> sv/pbor_flag_ram.sv
module pbor_flag_ram #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata
);

    logic r_mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/provided_buffer_ownership_ring.sv
// Buffer ownership tracker for a provided-buffer receive ring. After reset the
// in-ring flag memory is swept to zero, one entry per cycle; busy stays high
// through the sweep, while configuration writes are taken at any time. Each
// command then runs its steps in order: on accept the flag memory read is
// issued, in the LOOK state the block decides and writes the flag back while
// the id*size product is registered, and in the EMIT state it adds the base
// and registers the result. o_valid is high for one cycle once the result is
// registered, and start is taken again in that same cycle, so a new command is
// accepted only after the previous result is out. The result is not held: it must be taken on the
// cycle o_valid is high. Ring entry fields read zero when o_write_valid is low.
module provided_buffer_ownership_ring #(
    parameter int unsigned RING_DEPTH = pbor_pkg::RING_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [pbor_pkg::BASE_W-1:0]    i_cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic [pbor_pkg::ACT_W-1:0]     i_action,
    input  logic [pbor_pkg::ID_W-1:0]      i_buffer_id,
    output logic                           o_valid,
    output logic [pbor_pkg::STAT_W-1:0]    o_status,
    output logic                           o_write_valid,
    output logic [pbor_pkg::BYTE_W-1:0]    o_ring_slot,
    output logic [pbor_pkg::ADDR_W-1:0]    o_entry_addr,
    output logic [pbor_pkg::SIZE_W-1:0]    o_entry_len,
    output logic [pbor_pkg::BYTE_W-1:0]    o_entry_bid,
    output logic [pbor_pkg::TAIL_W-1:0]    o_published_tail,
    output logic [pbor_pkg::STALE_W-1:0]   o_stale_count
);

    import pbor_pkg::*;

    localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [AW-1:0]   LAST_IDX = AW'(RING_DEPTH - 1);
    localparam logic [ID_W:0]   ID_LIMIT = (ID_W + 1)'(RING_DEPTH);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    logic [ACT_W-1:0]    r_action, n_action;
    logic [ID_W-1:0]     r_id, n_id;
    logic [BASE_W-1:0]   r_base, n_base;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic [TAIL_W-1:0]   r_tail, n_tail;
    logic [AW-1:0]       r_slot, n_slot;
    logic [TAIL_W-1:0]   r_vis, n_vis;
    logic [STALE_W-1:0]  r_stale, n_stale;
    logic [STAT_W-1:0]   r_status, n_status;
    logic                r_wv, n_wv;
    logic [AW-1:0]       r_wslot, n_wslot;
    logic [PROD_W-1:0]   r_prod, n_prod;

    logic                r_out_valid, n_out_valid;
    logic [STAT_W-1:0]   r_out_status, n_out_status;
    logic                r_out_wv, n_out_wv;
    logic [BYTE_W-1:0]   r_out_slot, n_out_slot;
    logic [ADDR_W-1:0]   r_out_addr, n_out_addr;
    logic [SIZE_W-1:0]   r_out_len, n_out_len;
    logic [BYTE_W-1:0]   r_out_bid, n_out_bid;

    logic                accept;
    logic                in_range;
    logic                flag_rd;
    logic                flag_we;
    logic                flag_val;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic                ram_wdata;
    logic [TAIL_W-1:0]   wslot_wide;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && (r_state == S_IDLE);

    pbor_flag_ram #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_flags (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (i_buffer_id[AW-1:0]),
        .o_rdata (flag_rd)
    );

    // the sweep owns the write port until the flags are all clear
    assign ram_we    = (r_state == S_CLEAR) || ((r_state == S_LOOK) && flag_we);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr : r_id[AW-1:0];
    assign ram_wdata = (r_state == S_CLEAR) ? 1'b0 : flag_val;

    assign in_range   = {1'b0, r_id} < ID_LIMIT;
    assign wslot_wide = TAIL_W'(r_wslot);

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_action     = r_action;
        n_id         = r_id;
        n_base       = r_base;
        n_size       = r_size;
        n_tail       = r_tail;
        n_slot       = r_slot;
        n_vis        = r_vis;
        n_stale      = r_stale;
        n_status     = r_status;
        n_wv         = r_wv;
        n_wslot      = r_wslot;
        n_prod       = r_prod;
        n_out_valid  = 1'b0;
        n_out_status = r_out_status;
        n_out_wv     = r_out_wv;
        n_out_slot   = r_out_slot;
        n_out_addr   = r_out_addr;
        n_out_len    = r_out_len;
        n_out_bid    = r_out_bid;
        flag_we      = 1'b0;
        flag_val     = 1'b0;

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE: n_base = i_cfg_data;
                CFG_SIZE: n_size = i_cfg_data[SIZE_W-1:0];
                default:  n_base = r_base;
            endcase
        end

        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_action = i_action;
                    n_id     = i_buffer_id;
                    n_state  = S_LOOK;
                end
            end
            S_LOOK: begin
                n_status = ST_OK;
                n_wv     = 1'b0;
                n_wslot  = r_slot;
                n_prod   = PROD_W'(r_id) * PROD_W'(r_size);
                case (r_action)
                    ACT_RECYCLE: begin
                        if (!in_range || flag_rd) begin
                            n_status = ST_REJECT;
                        end else begin
                            n_wv     = 1'b1;
                            flag_we  = 1'b1;
                            flag_val = 1'b1;
                            n_tail   = r_tail + 1'b1;
                            // tail wrap lands on slot zero even for odd ring sizes
                            if (r_tail == '1 || r_slot == LAST_IDX) begin
                                n_slot = '0;
                            end else begin
                                n_slot = r_slot + 1'b1;
                            end
                        end
                    end
                    ACT_CLAIM: begin
                        if (!in_range || !flag_rd) begin
                            n_status = ST_STALE;
                            n_stale  = r_stale + 1'b1;
                        end else begin
                            flag_we  = 1'b1;
                            flag_val = 1'b0;
                        end
                    end
                    ACT_PUBLISH: begin
                        n_vis = r_tail;
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_out_valid  = 1'b1;
                n_out_status = r_status;
                n_out_wv     = r_wv;
                if (r_wv) begin
                    n_out_slot = wslot_wide[BYTE_W-1:0];
                    n_out_addr = ADDR_W'(r_base) + ADDR_W'(r_prod);
                    n_out_len  = r_size;
                    n_out_bid  = r_id[BYTE_W-1:0];
                end else begin
                    n_out_slot = '0;
                    n_out_addr = '0;
                    n_out_len  = '0;
                    n_out_bid  = '0;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_base      <= '0;
            r_size      <= SIZE_RESET;
            r_tail      <= '0;
            r_slot      <= '0;
            r_vis       <= '0;
            r_stale     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_base      <= n_base;
            r_size      <= n_size;
            r_tail      <= n_tail;
            r_slot      <= n_slot;
            r_vis       <= n_vis;
            r_stale     <= n_stale;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_id         <= n_id;
        r_status     <= n_status;
        r_wv         <= n_wv;
        r_wslot      <= n_wslot;
        r_prod       <= n_prod;
        r_out_status <= n_out_status;
        r_out_wv     <= n_out_wv;
        r_out_slot   <= n_out_slot;
        r_out_addr   <= n_out_addr;
        r_out_len    <= n_out_len;
        r_out_bid    <= n_out_bid;
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_write_valid    = r_out_wv;
    assign o_ring_slot      = r_out_slot;
    assign o_entry_addr     = r_out_addr;
    assign o_entry_len      = r_out_len;
    assign o_entry_bid      = r_out_bid;
    assign o_published_tail = r_vis;
    assign o_stale_count    = r_stale;

`ifndef ASSERT_OFF
    a_result_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 3))
        else $error("result beat without a command three cycles earlier");

    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_write_only_when_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_write_valid) |-> (o_status == ST_OK))
        else $error("ring write reported with a reject status");

    a_no_flag_write_in_sweep_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !accept)
        else $error("command accepted during flag sweep");
`endif

endmodule

>>> bench/provided_buffer_ownership_ring_tb.sv
module provided_buffer_ownership_ring_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pbor_pkg::*;

    localparam int unsigned RING_N = RING_DEPTH_DEF;
    // the 2-bit action field leaves one code the block must ignore
    localparam logic [ACT_W-1:0] ACT_IGNORED = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic               write_valid;
        logic [BYTE_W-1:0]  slot;
        logic [ADDR_W-1:0]  addr;
        logic [SIZE_W-1:0]  len;
        logic [BYTE_W-1:0]  bid;
        logic [TAIL_W-1:0]  tail;
        logic [STALE_W-1:0] stale;
    } t_ring_result;

    class ownership_ledger;
        logic [BASE_W-1:0]  base_addr;
        logic [SIZE_W-1:0]  buf_bytes;
        bit                 owned [RING_N];
        logic [TAIL_W-1:0]  prod_tail;
        logic [TAIL_W-1:0]  seen_tail;
        logic [STALE_W-1:0] stale_cnt;
        t_ring_result       awaited [$];
        int                 mismatch_count;

        function new();
            base_addr = '0;
            buf_bytes = SIZE_RESET;
            foreach (owned[i]) owned[i] = 1'b0;
            prod_tail = '0;
            seen_tail = '0;
            stale_cnt = '0;
            mismatch_count = 0;
        endfunction

        function void set_register(logic idx, logic [BASE_W-1:0] data);
            if (idx == CFG_BASE) begin
                base_addr = data;
            end else begin
                buf_bytes = data[SIZE_W-1:0];
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function bit holds(int unsigned id);
            return id < RING_N && owned[id];
        endfunction

        function void note_command(logic [ACT_W-1:0] act, logic [ID_W-1:0] id);
            t_ring_result r;
            bit in_range;
            r = '0;
            in_range = 32'(id) < RING_N;
            case (act)
                ACT_RECYCLE: begin
                    if (!in_range || owned[id]) begin
                        r.status = ST_REJECT;
                    end else begin
                        r.write_valid = 1'b1;
                        r.slot = 8'(32'(prod_tail) % RING_N);
                        r.addr = 64'(base_addr) + 64'(id) * 64'(buf_bytes);
                        r.len = buf_bytes;
                        r.bid = id[BYTE_W-1:0];
                        prod_tail = prod_tail + 16'd1;
                        owned[id] = 1'b1;
                    end
                end
                ACT_CLAIM: begin
                    if (!in_range || !owned[id]) begin
                        r.status = ST_STALE;
                        stale_cnt = stale_cnt + 32'd1;
                    end else begin
                        owned[id] = 1'b0;
                    end
                end
                ACT_PUBLISH: seen_tail = prod_tail;
                default: ;
            endcase
            r.tail = seen_tail;
            r.stale = stale_cnt;
            awaited.push_back(r);
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_result(t_ring_result got);
            t_ring_result want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result beat, status 0x%0h", $time, got.status);
                mismatch_count++;
                return;
            end
            want = awaited.pop_front();
            compare("status", 64'(want.status), 64'(got.status));
            compare("write_valid", 64'(want.write_valid), 64'(got.write_valid));
            compare("ring_slot", 64'(want.slot), 64'(got.slot));
            compare("entry_addr", want.addr, got.addr);
            compare("entry_len", 64'(want.len), 64'(got.len));
            compare("entry_bid", 64'(want.bid), 64'(got.bid));
            compare("published_tail", 64'(want.tail), 64'(got.tail));
            compare("stale_count", 64'(want.stale), 64'(got.stale));
        endfunction

        function void flag_leftovers();
            if (awaited.size() != 0) begin
                $display("%0t: %0d expected results never arrived", $time, awaited.size());
                mismatch_count += awaited.size();
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [BASE_W-1:0]   i_cfg_data;
    logic                start;
    logic                busy;
    logic [ACT_W-1:0]    i_action;
    logic [ID_W-1:0]     i_buffer_id;
    logic                o_valid;
    logic [STAT_W-1:0]   o_status;
    logic                o_write_valid;
    logic [BYTE_W-1:0]   o_ring_slot;
    logic [ADDR_W-1:0]   o_entry_addr;
    logic [SIZE_W-1:0]   o_entry_len;
    logic [BYTE_W-1:0]   o_entry_bid;
    logic [TAIL_W-1:0]   o_published_tail;
    logic [STALE_W-1:0]  o_stale_count;

    ownership_ledger ledger;
    int unsigned     pool_lo;

    provided_buffer_ownership_ring #(.RING_DEPTH(RING_N)) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_buffer_id      (i_buffer_id),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_write_valid    (o_write_valid),
        .o_ring_slot      (o_ring_slot),
        .o_entry_addr     (o_entry_addr),
        .o_entry_len      (o_entry_len),
        .o_entry_bid      (o_entry_bid),
        .o_published_tail (o_published_tail),
        .o_stale_count    (o_stale_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            ledger.check_result({o_status, o_write_valid, o_ring_slot, o_entry_addr,
                                 o_entry_len, o_entry_bid, o_published_tail,
                                 o_stale_count});
        end
    end

    // called at a falling edge; returns at the falling edge after the accept
    task automatic issue_cmd(logic [ACT_W-1:0] act, logic [ID_W-1:0] id);
        start <= 1'b1;
        i_action <= act;
        i_buffer_id <= id;
        do @(posedge i_clk); while (busy);
        ledger.note_command(act, id);
        @(negedge i_clk);
    endtask

    task automatic hold_off(int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [BASE_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        ledger.set_register(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (ledger.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic random_cmd(output logic [ACT_W-1:0] act, output logic [ID_W-1:0] id);
        int unsigned pick;
        int unsigned id_pick;
        pick = $urandom_range(0, 99);
        id_pick = $urandom_range(0, 99);
        if (pick < 42) act = ACT_RECYCLE;
        else if (pick < 80) act = ACT_CLAIM;
        else if (pick < 94) act = ACT_PUBLISH;
        else act = ACT_IGNORED;
        // narrow id pool so recycles and claims keep hitting the same buffers
        if (id_pick < 70) id = 16'(pool_lo + $urandom_range(0, 23));
        else if (id_pick < 88) id = 16'($urandom_range(0, RING_N - 1));
        else if (id_pick < 96) id = 16'($urandom_range(RING_N, 65535));
        else id = '1;
        // mostly claim what is actually in the ring
        if (act == ACT_CLAIM && !ledger.holds(32'(id)) && $urandom_range(0, 3) != 0) begin
            for (int k = 0; k < 24; k++) begin
                if (ledger.holds(pool_lo + k)) id = 16'(pool_lo + k);
            end
        end
    endtask

    task automatic random_run(int unsigned count);
        int unsigned left;
        int unsigned burst;
        logic [ACT_W-1:0] act;
        logic [ID_W-1:0] id;
        left = count;
        while (left > 0) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            for (int unsigned b = 0; b < burst && left > 0; b++) begin
                random_cmd(act, id);
                issue_cmd(act, id);
                left--;
            end
            hold_off($urandom_range(1, 10));
        end
    endtask

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int unsigned guard;
        logic [BASE_W-1:0] base_val;
        logic [BASE_W-1:0] size_val;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_BASE;
        i_cfg_data = '0;
        start = 1'b0;
        i_action = ACT_RECYCLE;
        i_buffer_id = '0;
        pool_lo = 0;
        ledger = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed beats on reset register values
        issue_cmd(ACT_CLAIM, 16'd0);
        issue_cmd(ACT_RECYCLE, 16'd0);
        issue_cmd(ACT_RECYCLE, 16'd0);
        issue_cmd(ACT_RECYCLE, 16'(RING_N - 1));
        issue_cmd(ACT_RECYCLE, 16'(RING_N));
        issue_cmd(ACT_RECYCLE, 16'hFFFF);
        issue_cmd(ACT_CLAIM, 16'hFFFF);
        issue_cmd(ACT_CLAIM, 16'(RING_N));
        issue_cmd(ACT_PUBLISH, 16'hFFFF);
        hold_off(2);
        issue_cmd(ACT_CLAIM, 16'd0);
        issue_cmd(ACT_CLAIM, 16'd0);
        issue_cmd(ACT_RECYCLE, 16'd0);
        issue_cmd(ACT_IGNORED, 16'hAAAA);
        issue_cmd(ACT_IGNORED, 16'h5555);
        issue_cmd(ACT_PUBLISH, 16'd0);
        hold_off(1);
        drain();

        write_reg(CFG_BASE, '1);
        write_reg(CFG_SIZE, 48'(32'hFFFF_FFFF));
        issue_cmd(ACT_RECYCLE, 16'(RING_N - 2));
        issue_cmd(ACT_RECYCLE, 16'd1);
        hold_off(1);
        drain();

        // zero size: address collapses to base, length zero
        write_reg(CFG_BASE, 48'h1234_5678_9ABC);
        write_reg(CFG_SIZE, 48'd0);
        issue_cmd(ACT_RECYCLE, 16'd7);
        issue_cmd(ACT_CLAIM, 16'(RING_N - 1));
        issue_cmd(ACT_CLAIM, 16'(RING_N - 2));
        issue_cmd(ACT_PUBLISH, 16'h00FF);
        hold_off(1);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            base_val = {16'($urandom), $urandom};
            size_val = 48'($urandom);
            case (ph)
                0: begin base_val = '0; size_val = 48'd1; end
                1: begin base_val = '1; size_val = 48'(32'hFFFF_FFFF); end
                2: size_val = '0;
                3: size_val = 48'(SIZE_RESET);
                5: begin base_val = '0; size_val = {16'($urandom), $urandom}; end
                default: ;
            endcase
            write_reg(CFG_BASE, base_val);
            write_reg(CFG_SIZE, size_val);
            pool_lo = $urandom_range(0, RING_N - 24);
            random_run(310);
            drain();
        end

        guard = 0;
        while (ledger.pending() != 0 && guard < 2000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (10) @(negedge i_clk);
        ledger.flag_leftovers();
        if (ledger.mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

>>> provided_buffer_ownership_ring.f
sv/pbor_pkg.sv
sv/pbor_flag_ram.sv
sv/provided_buffer_ownership_ring.sv
bench/provided_buffer_ownership_ring_tb.sv
